/* hdl/signed_binary_to_decimal_ascii_macros.svh */
// Assertion macros shared by the signed binary to decimal ASCII converter.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SBDA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SBDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sbda_pkg.sv */
// Shared constants and types of the signed binary to decimal ASCII converter.
`timescale 1ns / 1ps

package sbda_pkg;

  localparam int unsigned BinW      = 128;
  localparam int unsigned NumDigits = 39;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned CntW      = 7;
  localparam int unsigned CharW     = 6;

  localparam logic [CharW-1:0] CharZero  = 6'd48;
  localparam logic [CharW-1:0] CharMinus = 6'd45;

  localparam logic [CntW-1:0] LastStep    = CntW'(BinW - 1);
  localparam logic [CntW-1:0] DigitsCount = CntW'(NumDigits);

  // Command word from the sequencer to the shared conversion unit.
  typedef struct packed {
    logic load;
    logic step;
    logic digit_shift;
  } unit_cmd_t;

endpackage

/* hdl/sbda_dabble_unit.sv */
// Shared shift-and-add-3 unit that holds the binary word and the BCD digits.
`timescale 1ns / 1ps

module sbda_dabble_unit
  import sbda_pkg::*;
(
  input  logic            clk_i,
  input  unit_cmd_t       cmd_i,
  input  logic [BinW-1:0] mag_i,
  output logic [3:0]      top_digit_o
);

  logic [BinW-1:0] bin_q, bin_d;
  logic [BcdW-1:0] bcd_q, bcd_d;
  logic [BcdW-1:0] bcd_adj;

  // Every digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    if (cmd_i.load) begin
      bin_d = mag_i;
      bcd_d = '0;
    end else if (cmd_i.step) begin
      bin_d = {bin_q[BinW-2:0], 1'b0};
      bcd_d = {bcd_adj[BcdW-2:0], bin_q[BinW-1]};
    end else if (cmd_i.digit_shift) begin
      bcd_d = {bcd_q[BcdW-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign top_digit_o = bcd_q[BcdW-1 -: 4];

endmodule

/* hdl/signed_binary_to_decimal_ascii.sv */
// Top level: sequencer that converts a signed 128-bit value to decimal ASCII text.
//
// A number is taken when start is high and busy is low, and busy stays high
// until its text is out. The magnitude is converted by shift-and-add-3, one
// bit per cycle through the shared BCD unit. Leading zero digits are then
// dropped at one per cycle (39 minus the digit count), and the characters
// follow at one per cycle: the minus sign for a negative value, then the
// digits, the last one flagged. Each character is on the outputs for exactly
// one cycle with result_valid_o high; the receiver cannot stall the block,
// so it must take every character in the cycle it is shown.
`timescale 1ns / 1ps

`include "signed_binary_to_decimal_ascii_macros.svh"

module signed_binary_to_decimal_ascii
  import sbda_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [63:0] value_high_i,
  input  logic [63:0]        value_low_i,
  output logic [CharW-1:0]   char_code_o,
  output logic               last_char_o,
  output logic               result_valid_o
);

  typedef enum logic [2:0] {
    StIdle,
    StConvert,
    StSkip,
    StSign,
    StEmit
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  cnt_q;
  logic             neg_q;
  logic             valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q;

  unit_cmd_t        cmd;
  logic [BinW-1:0]  value;
  logic [BinW-1:0]  mag;
  logic [3:0]       top_digit;
  logic             accept;

  assign value  = {value_high_i, value_low_i};
  // Two's complement negation modulo 2^128, so the most negative value works.
  assign mag    = value_high_i[63] ? (~value + BinW'(1)) : value;
  assign accept = start && (state_q == StIdle);

  always_comb begin
    cmd             = '0;
    cmd.load        = accept;
    cmd.step        = (state_q == StConvert);
    cmd.digit_shift = ((state_q == StSkip) && (top_digit == 4'd0) && (cnt_q > CntW'(1)))
                      || (state_q == StEmit);
  end

  sbda_dabble_unit u_unit (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .mag_i       (mag),
    .top_digit_o (top_digit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      valid_q <= 1'b0;
      char_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start) begin
            state_q <= StConvert;
            cnt_q   <= '0;
            neg_q   <= value_high_i[63];
          end
        end
        StConvert: begin
          if (cnt_q == LastStep) begin
            state_q <= StSkip;
            cnt_q   <= DigitsCount;
          end else begin
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        StSkip: begin
          // The units digit is always kept, so zero prints as one digit.
          if ((top_digit == 4'd0) && (cnt_q > CntW'(1))) begin
            cnt_q <= cnt_q - CntW'(1);
          end else if (neg_q) begin
            state_q <= StSign;
          end else begin
            state_q <= StEmit;
          end
        end
        StSign: begin
          valid_q <= 1'b1;
          char_q  <= CharMinus;
          state_q <= StEmit;
        end
        StEmit: begin
          valid_q <= 1'b1;
          char_q  <= CharZero + CharW'(top_digit);
          cnt_q   <= cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            last_q  <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy           = (state_q != StIdle);
  assign char_code_o    = char_q;
  assign last_char_o    = last_q;
  assign result_valid_o = valid_q;

  `SBDA_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy, "busy did not rise after a start")
  `SBDA_ASSERT_SAME(a_sign_not_last, clk_i, rst_ni, result_valid_o && (char_code_o == CharMinus), !last_char_o, "minus sign flagged as last")
  `SBDA_ASSERT_SAME(a_char_range, clk_i, rst_ni, result_valid_o, (char_code_o == CharMinus) || ((char_code_o >= CharZero) && (char_code_o <= CharZero + 6'd9)), "character code out of range")
  `SBDA_ASSERT_NEXT(a_gap_after_last, clk_i, rst_ni, result_valid_o && last_char_o, !result_valid_o, "character after the last one of a number")

endmodule

/* tb/tb_signed_binary_to_decimal_ascii.sv */
// Testbench for the signed 128-bit binary to decimal ASCII converter.
`timescale 1ns / 1ps

module tb_signed_binary_to_decimal_ascii;
  import sbda_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } text_char_t;

  // Holds the characters still owed by the block and checks each one shown.
  class expected_text;
    text_char_t owed[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Works out the decimal text of an accepted number.
    function void note_number(logic signed [63:0] hi, logic [63:0] lo);
      logic [127:0] mag;
      logic         neg;
      logic [3:0]   digits[$];
      text_char_t   c;
      mag = {hi, lo};
      neg = mag[127];
      // The negation wraps modulo 2^128, so the most negative value stays 2^127.
      if (neg) begin
        mag = ~mag + 128'd1;
      end
      do begin
        digits.push_back(4'(mag % 128'd10));
        mag = mag / 128'd10;
      end while (mag != 128'd0);
      if (neg) begin
        c.code = CharMinus;
        c.last = 1'b0;
        owed.push_back(c);
      end
      for (int k = digits.size() - 1; k >= 0; k--) begin
        c.code = CharZero + CharW'(digits[k]);
        c.last = (k == 0);
        owed.push_back(c);
      end
    endfunction

    function void check_char(logic [CharW-1:0] code, logic last);
      text_char_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected character code=%0d last=%b", $realtime, code, last);
        end
        return;
      end
      want = owed.pop_front();
      if (code !== want.code || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: character mismatch: expected code=%0d last=%b, got code=%0d last=%b",
                   $realtime, want.code, want.last, code, last);
        end
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [63:0] value_high_i = '0;
  logic [63:0]        value_low_i = '0;
  logic [CharW-1:0]   char_code_o;
  logic               last_char_o;
  logic               result_valid_o;

  expected_text board = new();

  signed_binary_to_decimal_ascii dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .value_high_i   (value_high_i),
    .value_low_i    (value_low_i),
    .char_code_o    (char_code_o),
    .last_char_o    (last_char_o),
    .result_valid_o (result_valid_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Outputs are read just after the edge, before the block's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      board.check_char(char_code_o, last_char_o);
    end
  end

  // Start stays high across back-to-back numbers, so it is only lowered for a gap.
  task automatic send_number(logic [127:0] value, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    value_high_i <= value[127:64];
    value_low_i  <= value[63:0];
    do @(posedge clk_i); while (busy !== 1'b0);
    board.note_number(value[127:64], value[63:0]);
  endtask

  task automatic wait_drained();
    int cycles;
    cycles = 0;
    while (board.pending() > 0 && cycles < 5000) begin
      @(posedge clk_i);
      cycles++;
    end
  endtask

  function automatic logic [127:0] pow10(int k);
    logic [127:0] p;
    p = 128'd1;
    for (int i = 0; i < k; i++) begin
      p = p * 128'd10;
    end
    return p;
  endfunction

  function automatic logic [127:0] random_word();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  initial begin
    logic [127:0] directed[$];
    logic [127:0] mag;
    int           width;
    int           gap;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero, small values, the extremes and the decimal boundaries.
    directed = '{128'd0, 128'd1, -128'sd1, 128'd9, 128'd10, -128'sd10,
                 {1'b0, {127{1'b1}}}, {1'b1, 127'd0}, {1'b1, 126'd0, 1'b1},
                 {64'd0, {64{1'b1}}}, {64'd1, 64'd0}, {{64{1'b1}}, 64'd0},
                 pow10(19) - 128'd1, pow10(19), pow10(20), -pow10(20),
                 pow10(38) - 128'd1, pow10(38), -pow10(38), -(pow10(38) - 128'd1),
                 {64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa}};
    foreach (directed[i]) begin
      send_number(directed[i], $urandom_range(0, 15));
    end

    for (int i = 0; i < 190; i++) begin
      case ($urandom_range(0, 3))
        0: mag = random_word();
        1: begin
          // Spread the digit count by limiting the magnitude's width.
          width = $urandom_range(1, 127);
          mag = random_word() & ((128'd1 << width) - 128'd1);
          if ($urandom_range(0, 1)) mag = -mag;
        end
        2: begin
          mag = pow10($urandom_range(0, 38)) + 128'($urandom_range(0, 4)) - 128'd2;
          if ($urandom_range(0, 1)) mag = -mag;
        end
        default: begin
          mag = 128'($urandom_range(0, 1000));
          if ($urandom_range(0, 1)) mag = -mag;
        end
      endcase
      // Every third stretch of thirty transactions runs with no gaps at all.
      gap = ((i / 30) % 3 == 1) ? 0 : $urandom_range(0, 15);
      if (i == 95) begin
        // Start must be low while draining, or the block takes the old value again.
        start <= 1'b0;
        wait_drained();
      end
      send_number(mag, gap);
    end

    start <= 1'b0;
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("[signed_binary_to_decimal_ascii] OK");
    end else begin
      $display("[signed_binary_to_decimal_ascii] ERROR");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("[signed_binary_to_decimal_ascii] ERROR");
    $finish;
  end

endmodule

/* signed_binary_to_decimal_ascii.f */
+incdir+hdl
hdl/sbda_pkg.sv
hdl/sbda_dabble_unit.sv
hdl/signed_binary_to_decimal_ascii.sv
tb/tb_signed_binary_to_decimal_ascii.sv
